/* rtl/sorted_table_binary_search_defines.svh */
// Assertion macros used by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Checked property on clk_i, switched off while reset is asserted.
`define STBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property on clk_i that also holds during reset.
`define STBS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/stbs_pkg.sv */
// Types and constants shared by the sorted table search block.
`default_nettype none

package stbs_pkg;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned PROBE_W = 4;

  localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } stbs_state_e;

endpackage

`default_nettype wire

/* rtl/stbs_in_if.sv */
// Input channel: table write or search key words.
`default_nettype none

interface stbs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [stbs_pkg::POS_W-1:0]          position;
  logic signed [stbs_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

/* rtl/stbs_out_if.sv */
// Output channel: search result words.
`default_nettype none

interface stbs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stbs_pkg::POS_W-1:0]   match_position;
  logic [stbs_pkg::PROBE_W-1:0] probe_count;

  modport source (output valid, output found, output match_position, output probe_count,
                  input ready);
  modport sink   (input valid, input found, input match_position, input probe_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sorted_table_binary_search.sv */
// Top level: binary search over a sorted table of signed words held in one memory.
// A write word gives no result.
// A search makes P probes (P <= 11); each probe is a memory read then a compare,
// so the read-compare loop sets the rate, and no new word is taken until it is done.
// Reset clears control and the length register; table contents stay undefined.
`default_nettype none

`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [stbs_pkg::LEN_W-1:0]  cfg_wdata_i,
  stbs_in_if.sink                          in_i,
  stbs_out_if.source                       out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

  stbs_pkg::stbs_state_e state_q, state_d;

  logic [stbs_pkg::LEN_W-1:0]          table_length_q;
  logic [LW-1:0]                       lo_q, hi1_q, mid_q, mid_d, span;
  logic signed [stbs_pkg::VALUE_W-1:0] key_q;
  logic [stbs_pkg::PROBE_W-1:0]        probes_q;
  logic                                hit_q;

  logic                                out_valid_q, found_q;
  logic [stbs_pkg::POS_W-1:0]          match_q;
  logic [stbs_pkg::PROBE_W-1:0]        probe_count_q;

  logic                                in_ready, rd_en, load_result, range_open;
  logic                                in_fire, search_fire, wr_en;
  logic [31:0]                         pos32, mid32, len32;
  logic [stbs_pkg::VALUE_W-1:0]        rd_data;
  logic signed [stbs_pkg::VALUE_W-1:0] entry;
  logic                                key_eq, key_lt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (cfg_we_i) begin
      table_length_q <= cfg_wdata_i;
    end
  end

  assign in_fire     = in_i.valid && in_ready;
  assign search_fire = in_fire && (in_i.op == stbs_pkg::OP_SEARCH);
  assign pos32       = 32'(in_i.position);
  assign wr_en       = in_fire && (in_i.op == stbs_pkg::OP_WRITE) && (pos32 < 32'(TABLE_DEPTH));

  // Lengths beyond the table depth search the whole table.
  assign len32 = (32'(table_length_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                          : 32'(table_length_q);

  // The active range is [lo, hi1), so an empty range is lo == hi1.
  assign range_open = lo_q < hi1_q;
  assign span       = hi1_q - lo_q - LW'(1);
  assign mid_d      = lo_q + (span >> 1);
  assign mid32      = 32'(mid_q);

  assign entry  = $signed(rd_data);
  assign key_eq = key_q == entry;
  assign key_lt = key_q < entry;

  stbs_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pos32[AW-1:0]),
    .wdata_i (in_i.value),
    .re_i    (rd_en),
    .raddr_i (mid_d[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (search_fire) state_d = stbs_pkg::ST_PROBE;
      end
      stbs_pkg::ST_PROBE: begin
        state_d = range_open ? stbs_pkg::ST_CMP : stbs_pkg::ST_FINISH;
      end
      stbs_pkg::ST_CMP: begin
        state_d = key_eq ? stbs_pkg::ST_FINISH : stbs_pkg::ST_PROBE;
      end
      stbs_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) state_d = stbs_pkg::ST_IDLE;
      end
      default: state_d = stbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    load_result = 1'b0;
    case (state_q)
      stbs_pkg::ST_IDLE:   in_ready    = 1'b1;
      stbs_pkg::ST_PROBE:  rd_en       = range_open;
      stbs_pkg::ST_FINISH: load_result = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stbs_pkg::ST_IDLE;
      lo_q     <= '0;
      hi1_q    <= '0;
      mid_q    <= '0;
      probes_q <= '0;
      hit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        stbs_pkg::ST_IDLE: begin
          if (search_fire) begin
            lo_q     <= '0;
            hi1_q    <= len32[LW-1:0];
            probes_q <= '0;
            hit_q    <= 1'b0;
          end
        end
        stbs_pkg::ST_PROBE: begin
          if (range_open) mid_q <= mid_d;
        end
        stbs_pkg::ST_CMP: begin
          if (probes_q != stbs_pkg::PROBE_MAX) probes_q <= probes_q + 1'b1;
          if (key_eq) begin
            hit_q <= 1'b1;
          end else if (key_lt) begin
            hi1_q <= mid_q;
          end else begin
            lo_q <= mid_q + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (search_fire) key_q <= in_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      found_q       <= hit_q;
      match_q       <= hit_q ? mid32[stbs_pkg::POS_W-1:0] : '0;
      probe_count_q <= probes_q;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.found          = found_q;
  assign out_o.match_position = match_q;
  assign out_o.probe_count    = probe_count_q;

  `STBS_ASSERT(a_probe_then_cmp, (state_q == stbs_pkg::ST_PROBE && range_open) |=> (state_q == stbs_pkg::ST_CMP), "probe read not followed by compare")
  `STBS_ASSERT(a_mid_in_range, (state_q == stbs_pkg::ST_CMP) |-> (mid_q >= lo_q && mid_q < hi1_q), "probe midpoint outside active range")
  `STBS_ASSERT_ALWAYS(a_miss_pos_zero, (out_valid_q && !found_q) |-> (match_q == '0), "miss result carries a position")

endmodule

`default_nettype wire

/* rtl/stbs_ram.sv */
// Single-port-write, single-port-read table memory with registered read data.
`default_nettype none

module stbs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [stbs_pkg::VALUE_W-1:0]  wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output logic      [stbs_pkg::VALUE_W-1:0]  rdata_o
);

  logic [stbs_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [stbs_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sim/tb_sorted_table_binary_search.sv */
// Self-checking testbench for the sorted table binary search block.
`default_nettype none

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int DEPTH           = 1024;
  localparam int SETTLE_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 35;
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   match_pos;
    logic [PROBE_W-1:0] probes;
  } search_result_t;

  // Mirrors the table and the length register and predicts every search outcome.
  class search_checker;
    logic signed [VALUE_W-1:0] table_mem [DEPTH];
    logic [LEN_W-1:0]          length_reg = '0;
    search_result_t            pending_results [$];
    int                        errors   = 0;
    int                        searches = 0;
    int                        hits     = 0;

    function void set_length(logic [LEN_W-1:0] len);
      length_reg = len;
    endfunction

    function search_result_t predict_search(logic signed [VALUE_W-1:0] key);
      search_result_t res;
      int lo, hi, mid, span;
      res = '0;
      span = (length_reg > DEPTH) ? DEPTH : int'(length_reg);
      lo = 0;
      hi = span - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (res.probes < PROBE_MAX) res.probes++;
        if (key == table_mem[mid]) begin
          res.found = 1'b1;
          res.match_pos = mid[POS_W-1:0];
          break;
        end
        if (key < table_mem[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
      return res;
    endfunction

    function void note_word(logic op, logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] val);
      if (op == OP_WRITE) begin
        table_mem[pos] = val;
      end else begin
        pending_results.push_back(predict_search(val));
        searches++;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= SHOWN_MISMATCHES) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic found, logic [POS_W-1:0] pos, logic [PROBE_W-1:0] probes);
      search_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with no search outstanding (found %0b pos %0d probes %0d)",
                         found, pos, probes));
        return;
      end
      want = pending_results.pop_front();
      if (want.found) hits++;
      if (found !== want.found || pos !== want.match_pos || probes !== want.probes)
        report($sformatf("search result: found %0b/%0b pos %0d/%0d probes %0d/%0d (exp/act)",
                         want.found, found, want.match_pos, pos, want.probes, probes));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  stbs_in_if  in_if ();
  stbs_out_if out_if ();

  sorted_table_binary_search #(
    .TABLE_DEPTH (DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #6 clk_i = ~clk_i;

  search_checker    sb;
  longint           sorted_vals [DEPTH];
  logic [LEN_W-1:0] cur_len = '0;
  bit               calm_tx = 1'b0;
  int               n_writes = 0;
  int               n_lengths = 0;
  int               idle_cycles = 0;

  function automatic int active_entries();
    return (cur_len > DEPTH) ? DEPTH : int'(cur_len);
  endfunction

  // Leaves valid high across back-to-back words so it is never dropped and raised in one step.
  task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                           input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.position <= pos;
    in_if.value    <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_word(op, pos, val);
    if (op == OP_WRITE) n_writes++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // A trailing write word gives no result, so allow the block time to finish with it.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_table_length(input logic [LEN_W-1:0] len);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(len);
    cur_len = len;
    n_lengths++;
  endtask

  // Breaks the ordering of one entry, searches for the intruder, then puts the entry back.
  task automatic disturb_entry();
    logic [POS_W-1:0]          p;
    logic signed [VALUE_W-1:0] noise;
    p = POS_W'((active_entries() > 0) ? $urandom_range(0, active_entries() - 1)
                                      : $urandom_range(0, DEPTH - 1));
    noise = $urandom;
    send_word(OP_WRITE, p, noise);
    send_word(OP_SEARCH, POS_W'($urandom), noise);
    send_word(OP_WRITE, p, VALUE_W'(sorted_vals[p]));
  endtask

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int  stall;
    int  count;
    bit  calm_rx;
    count = 0;
    calm_rx = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (count % 64 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      stall = calm_rx ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_result(out_if.found, out_if.match_position, out_if.probe_count);
      count++;
    end
  end

  initial begin
    int                        phase, sent, r, idx;
    bit                        paused;
    logic [LEN_W-1:0]          new_len;
    logic [POS_W-1:0]          p;
    longint                    lo, hi, span_rand;
    logic signed [VALUE_W-1:0] key;

    sb = new();
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_WRITE;
    in_if.position <= '0;
    in_if.value    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The length is still zero from reset, so these searches see an empty table.
    send_word(OP_SEARCH, '0, KEY_MIN);
    send_word(OP_SEARCH, '1, KEY_MAX);

    // Fill every entry in ascending order, pinning both ends to the extremes of the range.
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) sorted_vals[i] = longint'(KEY_MIN);
      else if (i == DEPTH - 1) sorted_vals[i] = longint'(KEY_MAX);
      else sorted_vals[i] = longint'(KEY_MIN) + longint'(i) * 4194304
                            + $urandom_range(0, 4194303);
      send_word(OP_WRITE, i[POS_W-1:0], VALUE_W'(sorted_vals[i]));
    end

    set_table_length(LEN_W'(1));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[0]));
    send_word(OP_SEARCH, POS_W'($urandom), KEY_MAX);
    set_table_length(LEN_W'(2));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[1]));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[0] + 1));
    set_table_length(LEN_W'(DEPTH));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[DEPTH - 1]));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[0]));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[511]));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[700] + 1));
    send_word(OP_SEARCH, POS_W'($urandom), '0);
    // Lengths past the table depth must behave as the full table.
    set_table_length(LEN_W'(2047));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[DEPTH - 1]));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[1000]));
    set_table_length(LEN_W'(DEPTH + 1));
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[512]));
    disturb_entry();
    set_table_length('0);
    send_word(OP_SEARCH, POS_W'($urandom), VALUE_W'(sorted_vals[5]));

    paused = 1'b0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       new_len = LEN_W'($urandom_range(1, 8));
        1:       new_len = LEN_W'($urandom_range(1, DEPTH));
        2:       new_len = LEN_W'(DEPTH);
        3:       new_len = LEN_W'($urandom_range(DEPTH + 1, 2047));
        4:       new_len = LEN_W'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 64));
        default: new_len = LEN_W'($urandom_range(9, 200));
      endcase
      set_table_length(new_len);
      calm_tx = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == 3 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
          idx = (active_entries() > 0) ? $urandom_range(0, active_entries() - 1) : 0;
          r = $urandom_range(0, 99);
          if (r < 60) key = VALUE_W'(sorted_vals[idx]);
          else if (r < 75)
            key = VALUE_W'(sorted_vals[idx] + (($urandom_range(0, 1) != 0) ? 1 : -1));
          else if (r < 90) key = $urandom;
          else key = ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
          send_word(OP_SEARCH, POS_W'($urandom), key);
          sent++;
        end else if (r < 92) begin
          // Rewrite an entry with a value that keeps the table in ascending order.
          p  = POS_W'($urandom_range(0, DEPTH - 1));
          lo = (p == 0) ? longint'(KEY_MIN) : sorted_vals[p - 1];
          hi = (p == DEPTH - 1) ? longint'(KEY_MAX) : sorted_vals[p + 1];
          span_rand = {32'd0, $urandom};
          sorted_vals[p] = lo + span_rand % (hi - lo + 1);
          send_word(OP_WRITE, p, VALUE_W'(sorted_vals[p]));
          sent++;
        end else begin
          disturb_entry();
          sent += 3;
        end
      end
    end

    settle();
    $display("Covered %0d table writes and %0d searches (%0d hits) across %0d length settings,",
             n_writes, sb.searches, sb.hits, n_lengths);
    $display("including empty, single-entry, full and beyond-depth tables and unsorted entries.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d searches still outstanding", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_in_if.sv
rtl/stbs_out_if.sv
rtl/stbs_ram.sv
rtl/sorted_table_binary_search.sv
sim/tb_sorted_table_binary_search.sv
